// File: hw/rtl/priority_round_robin_aging_scheduler_defines.svh
// Assertion macros for the priority round robin aging scheduler.
// No dependencies.
`ifndef PRIORITY_ROUND_ROBIN_AGING_SCHEDULER_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_AGING_SCHEDULER_DEFINES_SVH
// implication checked on every clock, off during reset
`define PRRAS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, off during reset
`define PRRAS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: hw/rtl/prras_pkg.sv
// Shared types and constants for the priority round robin aging scheduler.
// No dependencies.
`timescale 1ns / 1ps
package prras_pkg;
   localparam int NumTasksDefault = 8;
   localparam int MapWidth = 16;
   localparam logic [7:0] QuantumReset = 8'd2;
   localparam logic [3:0] AgingReset = 4'd1;
   localparam logic CsrQuantum = 1'b0;
   localparam logic CsrAging = 1'b1;
   localparam logic KindLoad = 1'b0;
   localparam logic KindTick = 1'b1;
   localparam logic [1:0] CodeIdle = 2'd0;
   localparam logic [1:0] CodeRun = 2'd1;
   localparam logic [1:0] CodeWait = 2'd2;

   // one task table entry
   typedef struct packed {
      logic [15:0] arrival;
      logic [15:0] remaining;
      logic [7:0]  base_prio;
      logic [7:0]  dyn_prio;
      logic [15:0] sw_count;
   } task_type;

   // memory port request from the sequencer
   typedef struct packed {
      logic     we;
      task_type wdata;
   } mem_req_type;
endpackage

// File: hw/rtl/priority_round_robin_aging_scheduler.sv
// Top level of the priority round robin aging scheduler: sequencer and table.
// Depends on prras_pkg and prras_task_mem.
`timescale 1ns / 1ps
// A load transfer holds busy high for one cycle while its table entry is written.
// After reset a clearing pass over the task table writes zero to every entry
// with busy high. A tick holds busy high for three read passes over the table
// (best candidate; write back of aging, priority, remaining work and switch
// count; state map and done flag), the decision state and the result state.
// The single table read port is why these steps run as separate passes. The
// result is shown for one cycle on rsp_valid, in the first cycle with busy low,
// and cannot be stalled.
module priority_round_robin_aging_scheduler
   import prras_pkg::*;
#(
   parameter int NUM_TASKS = NumTasksDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [2:0]  req_slot,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_burst_length,
   input  logic [7:0]  req_base_priority,
   output logic        rsp_valid,
   output logic        rsp_running_valid,
   output logic [2:0]  rsp_running_slot,
   output logic [15:0] rsp_state_map,
   output logic        rsp_switch_valid,
   output logic [2:0]  rsp_switched_slot,
   output logic [15:0] rsp_switched_count,
   output logic        rsp_all_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   localparam int AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] Last = CW'(NUM_TASKS - 1);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_SCAN  = 7'b0000100,
      ST_DEC   = 7'b0001000,
      ST_UPD   = 7'b0010000,
      ST_MAP   = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rv_ff, rv_in;   // read data valid for entry cnt-1
   logic [7:0]  quantum_ff;
   logic [3:0]  aging_ff;
   logic [AW-1:0] cur_slot_ff, cur_slot_in;
   logic        cur_valid_ff, cur_valid_in;
   logic [7:0]  slice_ff, slice_in;
   logic [15:0] elapsed_ff, elapsed_in;
   // request latch
   logic        kind_ff;
   logic [2:0]  slot_ff;
   logic [15:0] arr_ff, burst_ff;
   logic [7:0]  bprio_ff;
   // scan results
   logic        cand_ok_ff, cand_ok_in;
   logic [AW-1:0] cand_ff, cand_in;
   logic [7:0]  cand_p_ff, cand_p_in;
   logic        live_ff, live_in;
   logic [7:0]  cur_p_ff, cur_p_in;
   // decision
   logic        ran_ff, ran_in, sw_ff, sw_in;
   logic [AW-1:0] run_ff, run_in, sws_ff, sws_in;
   logic [15:0] swc_ff, swc_in;
   logic        age_ff, age_in;
   logic [15:0] map_ff, map_in;
   logic        done_ff, done_in;

   logic [AW-1:0] raddr, waddr;
   mem_req_type   mreq;
   task_type      rdata;
   logic [AW-1:0] ridx;
   logic          rdy;

   prras_task_mem #(.NUM_TASKS(NUM_TASKS)) u_mem (
      .clock(clock), .waddr(waddr), .req(mreq), .raddr(raddr), .rdata(rdata)
   );

   assign ridx = AW'(cnt_ff - CW'(1));
   assign rdy = (rdata.remaining != 16'd0) && (rdata.arrival <= elapsed_ff);
   assign raddr = AW'(cnt_ff);
   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QuantumReset;
         aging_ff <= AgingReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrQuantum: quantum_ff <= csr_wdata;
            CsrAging:   aging_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      task_type w;
      logic [8:0] aged;
      logic [1:0] code;
      logic [7:0] sl;
      state_in = state_ff; cnt_in = cnt_ff; rv_in = 1'b0;
      cur_slot_in = cur_slot_ff; cur_valid_in = cur_valid_ff;
      slice_in = slice_ff; elapsed_in = elapsed_ff;
      cand_ok_in = cand_ok_ff; cand_in = cand_ff; cand_p_in = cand_p_ff;
      live_in = live_ff; cur_p_in = cur_p_ff;
      ran_in = ran_ff; sw_in = sw_ff; run_in = run_ff; sws_in = sws_ff;
      swc_in = swc_ff; age_in = age_ff; map_in = map_ff; done_in = done_ff;
      mreq.we = 1'b0; mreq.wdata = rdata; waddr = ridx;
      w = rdata; aged = '0; code = CodeIdle; sl = 8'd0;
      case (state_ff)
         ST_CLEAR: begin
            mreq.we = 1'b1; mreq.wdata = '0; waddr = AW'(cnt_ff);
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == Last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               cand_ok_in = 1'b0; live_in = 1'b0;
               map_in = '0; done_in = 1'b1;
               state_in = (req_kind == KindTick) ? ST_SCAN : ST_DEC;
               // loads go straight to a write in ST_DEC
            end
         end
         ST_SCAN: begin
            if (cnt_ff != CW'(NUM_TASKS)) begin
               cnt_in = cnt_ff + CW'(1);
               rv_in = 1'b1;
            end
            if (rv_ff) begin
               if (cur_valid_ff && ridx == cur_slot_ff) begin
                  live_in = rdy; cur_p_in = rdata.dyn_prio;
               end else if (rdy && (!cand_ok_ff || rdata.dyn_prio > cand_p_ff)) begin
                  cand_ok_in = 1'b1; cand_in = ridx; cand_p_in = rdata.dyn_prio;
               end
            end
            if (cnt_ff == CW'(NUM_TASKS) && !rv_ff) begin
               state_in = ST_DEC; cnt_in = '0;
            end
         end
         ST_DEC: begin
            if (kind_ff == KindLoad) begin
               w.arrival = arr_ff; w.remaining = burst_ff;
               w.base_prio = bprio_ff; w.dyn_prio = bprio_ff; w.sw_count = '0;
               mreq.wdata = w; waddr = AW'(slot_ff);
               mreq.we = (int'(slot_ff) < NUM_TASKS);
               state_in = ST_IDLE;
            end else begin
               sl = slice_ff;
               ran_in = 1'b0; sw_in = 1'b0; sws_in = '0; run_in = '0;
               if (live_ff) begin
                  ran_in = 1'b1; run_in = cur_slot_ff;
                  if (cand_ok_ff && (cand_p_ff > cur_p_ff || slice_ff >= quantum_ff)) begin
                     sw_in = 1'b1; sws_in = cur_slot_ff; run_in = cand_ff; sl = 8'd0;
                  end
               end else if (cand_ok_ff) begin
                  ran_in = 1'b1; run_in = cand_ff; sl = 8'd0;
               end
               if (live_ff || cand_ok_ff) begin
                  if (sl != 8'hFF) sl = sl + 8'd1;
                  slice_in = sl;
                  cur_slot_in = run_in; cur_valid_in = 1'b1;
               end else begin
                  cur_valid_in = 1'b0;
               end
               age_in = (sl >= quantum_ff);
               swc_in = '0;
               state_in = ST_UPD; cnt_in = '0;
            end
         end
         ST_UPD: begin
            // read pass writes back each entry
            if (cnt_ff != CW'(NUM_TASKS)) begin
               cnt_in = cnt_ff + CW'(1);
               rv_in = 1'b1;
            end
            if (rv_ff) begin
               if (ran_ff && ridx == run_ff) begin
                  w.dyn_prio = rdata.base_prio;
                  w.remaining = rdata.remaining - 16'd1;
               end else if (rdy && age_ff && ran_ff) begin
                  aged = {1'b0, rdata.dyn_prio} + {5'd0, aging_ff};
                  w.dyn_prio = aged[8] ? 8'hFF : aged[7:0];
               end
               if (sw_ff && ridx == sws_ff) begin
                  if (rdata.sw_count != 16'hFFFF) w.sw_count = rdata.sw_count + 16'd1;
                  swc_in = w.sw_count;
               end
               mreq.we = 1'b1; mreq.wdata = w;
            end
            if (cnt_ff == CW'(NUM_TASKS) && !rv_ff) begin
               state_in = ST_MAP; cnt_in = '0;
            end
         end
         ST_MAP: begin
            if (cnt_ff != CW'(NUM_TASKS)) begin
               cnt_in = cnt_ff + CW'(1);
               rv_in = 1'b1;
            end
            if (rv_ff) begin
               if (ran_ff && ridx == run_ff) code = CodeRun;
               else if (rdy) code = CodeWait;
               if (int'(ridx) < 8) map_in[2*ridx +: 2] = code;
               if (rdata.remaining != 16'd0) done_in = 1'b0;
            end
            if (cnt_ff == CW'(NUM_TASKS) && !rv_ff) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (elapsed_ff != 16'hFFFF) elapsed_in = elapsed_ff + 16'd1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; cnt_ff <= '0; rv_ff <= 1'b0;
         cur_slot_ff <= '0; cur_valid_ff <= 1'b0; slice_ff <= '0; elapsed_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; rv_ff <= rv_in;
         cur_slot_ff <= cur_slot_in; cur_valid_ff <= cur_valid_in;
         slice_ff <= slice_in; elapsed_ff <= elapsed_in;
         rsp_valid <= (state_ff == ST_RESP);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         kind_ff <= req_kind; slot_ff <= req_slot; arr_ff <= req_arrival_time;
         burst_ff <= req_burst_length; bprio_ff <= req_base_priority;
      end
      cand_ok_ff <= cand_ok_in; cand_ff <= cand_in; cand_p_ff <= cand_p_in;
      live_ff <= live_in; cur_p_ff <= cur_p_in;
      ran_ff <= ran_in; sw_ff <= sw_in; run_ff <= run_in; sws_ff <= sws_in;
      swc_ff <= swc_in; age_ff <= age_in; map_ff <= map_in; done_ff <= done_in;
      if (state_ff == ST_RESP) begin
         rsp_running_valid <= ran_ff;
         rsp_running_slot <= ran_ff ? 3'(run_ff) : 3'd0;
         rsp_state_map <= map_ff;
         rsp_switch_valid <= sw_ff;
         rsp_switched_slot <= sw_ff ? 3'(sws_ff) : 3'd0;
         rsp_switched_count <= sw_ff ? swc_ff : 16'd0;
         rsp_all_done <= done_ff;
      end
   end
endmodule

// File: hw/rtl/prras_task_mem.sv
// Task table memory: one write port, one registered read port.
// Depends on prras_pkg.
`timescale 1ns / 1ps
module prras_task_mem
   import prras_pkg::*;
#(
   parameter int NUM_TASKS = NumTasksDefault,
   localparam int AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
   input  logic        clock,
   input  logic [AW-1:0] waddr,
   input  mem_req_type req,
   input  logic [AW-1:0] raddr,
   output task_type    rdata
);
   task_type mem_ff [NUM_TASKS];

   // synchronous write and read
   always_ff @(posedge clock) begin
      if (req.we) begin
         mem_ff[waddr] <= req.wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

// File: hw/rtl/prras_checker.sv
// Port-level checker for the scheduler, bound to the top level.
// Depends on priority_round_robin_aging_scheduler_defines.svh.
`timescale 1ns / 1ps
`include "priority_round_robin_aging_scheduler_defines.svh"
module prras_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_kind,
   input logic       rsp_valid,
   input logic       rsp_running_valid,
   input logic [2:0] rsp_running_slot,
   input logic       rsp_switch_valid,
   input logic [2:0] rsp_switched_slot,
   input logic [15:0] rsp_switched_count
);
   `PRRAS_ASSERT_NXT(a_tick_busy, clock, reset, start && !busy && req_kind, busy, "tick not busy")
   `PRRAS_ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid, !busy, "result while busy")
   `PRRAS_ASSERT_IMP(a_sw_run, clock, reset, rsp_valid && rsp_switch_valid, rsp_running_valid && rsp_running_slot != rsp_switched_slot, "bad switch")
   `PRRAS_ASSERT_IMP(a_sw_cnt, clock, reset, rsp_valid && rsp_switch_valid, rsp_switched_count != 16'd0, "zero count")
endmodule

bind priority_round_robin_aging_scheduler prras_checker u_prras_checker (.*);

// File: tb/priority_round_robin_aging_scheduler_test.sv
// Self-checking testbench for the priority round robin aging scheduler.
// Depends on prras_pkg and the scheduler RTL; predicts every tick result internally.
`timescale 1ns / 1ps
module priority_round_robin_aging_scheduler_test;
   import prras_pkg::*;

   localparam int NTASK = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_kind = KindLoad;
   logic [2:0]  req_slot = '0;
   logic [15:0] req_arrival_time = '0;
   logic [15:0] req_burst_length = '0;
   logic [7:0]  req_base_priority = '0;
   logic        rsp_valid;
   logic        rsp_running_valid;
   logic [2:0]  rsp_running_slot;
   logic [15:0] rsp_state_map;
   logic        rsp_switch_valid;
   logic [2:0]  rsp_switched_slot;
   logic [15:0] rsp_switched_count;
   logic        rsp_all_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CsrQuantum;
   logic [7:0]  csr_wdata = '0;

   priority_round_robin_aging_scheduler u_top (.*);

   // one predicted tick outcome
   typedef struct packed {
      logic        running_valid;
      logic [2:0]  running_slot;
      logic [15:0] state_map;
      logic        switch_valid;
      logic [2:0]  switched_slot;
      logic [15:0] switched_count;
      logic        all_done;
   } tick_outcome_type;

   tick_outcome_type tick_outcomes[$];
   int  error_count = 0;
   bit  allow_gaps = 1'b1;

   // scheduler shadow state
   logic [15:0] sh_arrival[NTASK];
   logic [15:0] sh_remaining[NTASK];
   logic [7:0]  sh_base[NTASK];
   logic [7:0]  sh_dyn[NTASK];
   logic [15:0] sh_switches[NTASK];
   logic [2:0]  sh_cur_slot;
   logic        sh_cur_valid;
   logic [7:0]  sh_slice;
   logic [15:0] sh_elapsed;
   logic [7:0]  sh_quantum;
   logic [3:0]  sh_aging;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("priority_round_robin_aging_scheduler_test: errors");
      $finish;
   end

   function automatic bit task_ready(int i);
      return sh_remaining[i] != 0 && sh_arrival[i] <= sh_elapsed;
   endfunction

   // best ready slot other than the skipped one, -1 if none
   function automatic int best_ready(bit skip_valid, int skip);
      int best;
      best = -1;
      for (int i = 0; i < NTASK; i++) begin
         if (skip_valid && i == skip) continue;
         if (!task_ready(i)) continue;
         if (best < 0 || sh_dyn[i] > sh_dyn[best]) best = i;
      end
      return best;
   endfunction

   // apply one accepted item to the shadow state; ticks queue an outcome
   task automatic schedule_model(logic kind, logic [2:0] slot, logic [15:0] arr,
                                 logic [15:0] burst, logic [7:0] prio);
      tick_outcome_type o;
      bit live, take, ran;
      int cand, run;
      logic [8:0] aged;
      logic [1:0] code;
      o = '0;
      ran = 1'b0;
      run = 0;
      if (kind == KindLoad) begin
         sh_arrival[slot] = arr;
         sh_remaining[slot] = burst;
         sh_base[slot] = prio;
         sh_dyn[slot] = prio;
         sh_switches[slot] = '0;
         return;
      end
      live = sh_cur_valid && task_ready(int'(sh_cur_slot));
      cand = best_ready(live, int'(sh_cur_slot));
      if (live) begin
         take = cand >= 0 && (sh_dyn[cand] > sh_dyn[sh_cur_slot] || sh_slice >= sh_quantum);
         if (take) begin
            o.switch_valid = 1'b1;
            o.switched_slot = sh_cur_slot;
            if (sh_switches[sh_cur_slot] != 16'hFFFF)
               sh_switches[sh_cur_slot] = sh_switches[sh_cur_slot] + 16'd1;
            o.switched_count = sh_switches[sh_cur_slot];
            run = cand;
            sh_slice = '0;
         end else begin
            run = int'(sh_cur_slot);
         end
         ran = 1'b1;
      end else if (cand >= 0) begin
         run = cand;
         sh_slice = '0;
         ran = 1'b1;
      end
      if (ran) begin
         sh_cur_slot = run[2:0];
         sh_cur_valid = 1'b1;
         sh_dyn[run] = sh_base[run];
         sh_remaining[run] = sh_remaining[run] - 16'd1;
         if (sh_slice != 8'hFF) sh_slice = sh_slice + 8'd1;
         for (int i = 0; i < NTASK; i++) begin
            if (i != run && task_ready(i) && sh_slice >= sh_quantum) begin
               aged = {1'b0, sh_dyn[i]} + {5'd0, sh_aging};
               sh_dyn[i] = aged[8] ? 8'hFF : aged[7:0];
            end
         end
      end else begin
         sh_cur_valid = 1'b0;
      end
      o.running_valid = ran;
      o.running_slot = ran ? run[2:0] : 3'd0;
      o.all_done = 1'b1;
      for (int i = 0; i < NTASK; i++) begin
         code = CodeIdle;
         if (ran && i == run) code = CodeRun;
         else if (task_ready(i)) code = CodeWait;
         o.state_map[2*i +: 2] = code;
         if (sh_remaining[i] != 0) o.all_done = 1'b0;
      end
      if (sh_elapsed != 16'hFFFF) sh_elapsed = sh_elapsed + 16'd1;
      tick_outcomes.insert(tick_outcomes.size(), o);
   endtask

   // random idle burst on the command side
   task automatic maybe_gap();
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   // one command transfer; start stays high for a following item
   task automatic send_item(logic kind, logic [2:0] slot, logic [15:0] arr,
                            logic [15:0] burst, logic [7:0] prio);
      maybe_gap();
      start = 1'b1;
      req_kind = kind;
      req_slot = slot;
      req_arrival_time = arr;
      req_burst_length = burst;
      req_base_priority = prio;
      do @(posedge clock); while (busy);
      schedule_model(kind, slot, arr, burst, prio);
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_item(KindTick, 3'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   // wait for all outcomes plus the tail of a trailing load
   task automatic drain();
      start = 1'b0;
      while (tick_outcomes.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [7:0] data);
      drain();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CsrQuantum) sh_quantum = data;
      else sh_aging = data[3:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_policy(logic [7:0] q, logic [3:0] a);
      write_csr(CsrQuantum, q);
      write_csr(CsrAging, {4'd0, a});
   endtask

   // field extremes, idle ticks, preemption, ties
   task automatic test_directed();
      send_tick();
      send_item(KindLoad, 3'd7, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_item(KindLoad, 3'd0, 16'd0, 16'd3, 8'd0);
      send_item(KindLoad, 3'd1, 16'd0, 16'd3, 8'd0);
      repeat (3) send_tick();
      send_item(KindLoad, 3'd2, 16'd0, 16'd2, 8'd200);
      repeat (3) send_tick();
      send_item(KindLoad, 3'd0, 16'd0, 16'd2, 8'd10);
      send_tick();
      send_item(KindLoad, 3'd0, 16'd0, 16'd0, 8'd0);
      send_item(KindLoad, 3'd7, 16'd0, 16'd0, 8'd0);
      repeat (6) send_tick();
   endtask

   // one task runs long enough to saturate the slice counter
   task automatic test_long_slice();
      set_policy(8'd255, 4'd15);
      send_item(KindLoad, 3'd4, 16'd0, 16'd300, 8'd250);
      send_item(KindLoad, 3'd5, 16'd0, 16'd2, 8'd250);
      repeat (290) send_tick();
      send_item(KindLoad, 3'd4, 16'd0, 16'd0, 8'd0);
      send_item(KindLoad, 3'd5, 16'd0, 16'd0, 8'd0);
   endtask

   // task sets with random content, plus some full-range noise
   task automatic test_workload(int n_items);
      int sent, k;
      sent = 0;
      while (sent < n_items) begin
         k = $urandom_range(1, 4);
         repeat (k) begin
            if ($urandom_range(0, 9) == 0)
               send_item(KindLoad, 3'($urandom), 16'($urandom), 16'($urandom),
                         8'($urandom));
            else
               send_item(KindLoad, 3'($urandom), 16'(sh_elapsed + $urandom_range(0, 6)),
                         16'($urandom_range(0, 12)), 8'($urandom));
            sent++;
         end
         repeat ($urandom_range(4, 30)) begin
            send_tick();
            sent++;
         end
      end
   endtask

   // tick outcome check
   always @(posedge clock) begin
      tick_outcome_type w, g;
      if (!reset && rsp_valid) begin
         g = {rsp_running_valid, rsp_running_slot, rsp_state_map, rsp_switch_valid,
              rsp_switched_slot, rsp_switched_count, rsp_all_done};
         if (tick_outcomes.size() == 0) begin
            $display("%0t unexpected tick outcome: expected none, actual %h", $time, g);
            error_count++;
         end else begin
            w = tick_outcomes.pop_front();
            if (w.running_valid !== g.running_valid || w.running_slot !== g.running_slot) begin
               $display("%0t running: expected %b/%0d, actual %b/%0d", $time,
                        w.running_valid, w.running_slot, g.running_valid, g.running_slot);
               error_count++;
            end
            if (w.state_map !== g.state_map) begin
               $display("%0t state_map: expected %h, actual %h", $time,
                        w.state_map, g.state_map);
               error_count++;
            end
            if (w.switch_valid !== g.switch_valid || w.switched_slot !== g.switched_slot ||
                w.switched_count !== g.switched_count) begin
               $display("%0t switch: expected %b/%0d/%0d, actual %b/%0d/%0d", $time,
                        w.switch_valid, w.switched_slot, w.switched_count,
                        g.switch_valid, g.switched_slot, g.switched_count);
               error_count++;
            end
            if (w.all_done !== g.all_done) begin
               $display("%0t all_done: expected %b, actual %b", $time,
                        w.all_done, g.all_done);
               error_count++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < NTASK; i++) begin
         sh_arrival[i] = '0;
         sh_remaining[i] = '0;
         sh_base[i] = '0;
         sh_dyn[i] = '0;
         sh_switches[i] = '0;
      end
      sh_cur_slot = '0;
      sh_cur_valid = 1'b0;
      sh_slice = '0;
      sh_elapsed = '0;
      sh_quantum = QuantumReset;
      sh_aging = AgingReset;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_workload(100);
      set_policy(8'd1, 4'd0);
      test_workload(100);
      set_policy(8'd0, 4'd15);
      test_workload(100);
      test_long_slice();
      set_policy(8'd3, 4'd7);
      test_workload(100);
      set_policy(8'd2, 4'd1);
      allow_gaps = 1'b0;
      test_workload(100);

      drain();
      if (tick_outcomes.size() == 0 && error_count == 0)
         $display("priority_round_robin_aging_scheduler_test: clean");
      else
         $display("priority_round_robin_aging_scheduler_test: errors");
      $finish;
   end
endmodule

// File: priority_round_robin_aging_scheduler.f
+incdir+hw/rtl
hw/rtl/prras_pkg.sv
hw/rtl/prras_task_mem.sv
hw/rtl/priority_round_robin_aging_scheduler.sv
hw/rtl/prras_checker.sv
tb/priority_round_robin_aging_scheduler_test.sv
